// ===== rtl/core/hpw_pkg.sv =====
// ----------------------------------------------------------------------------
// hpw_pkg
// Shared types, widths, register codes and saturation helper for the heading
// PID wheel speed block.
// ----------------------------------------------------------------------------
package hpw_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int SUM_BITS_DEF   = 32;

  localparam int HEAD_W     = 16;
  localparam int SPEED_W    = 16;
  localparam int GAIN_W     = 24;
  localparam int SENS_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // shared multiplier: zero-extended gain times a signed operand
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

  localparam int ACC_W      = 64;
  localparam int MAG_W      = 48;
  localparam int SLICE_W    = 24;
  localparam int IP_W       = MAG_W + SLICE_W;
  localparam int CLAMP_EXP  = 60;
  localparam int ICL_W      = CLAMP_EXP + 1;
  localparam int CORR_SHIFT = 24;
  localparam int SENS_SHIFT = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_STEER_SENS = CFG_IDX_W'(3);

  localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'(96510);
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = GAIN_W'(40);
  localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = GAIN_W'(14476);
  localparam logic [SENS_W-1:0] STEER_SENS_RST = SENS_W'(256);

  localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] S16_MIN = -ACC_W'(32768);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_ILO,
    ST_MUL_IHI,
    ST_CLAMP,
    ST_ADD_I,
    ST_CORR,
    ST_MUL_S,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic   cmd_ready;
    logic   out_load;
    logic   mul_en;
    state_t step;
  } seq_ctrl_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_prop;
    logic [GAIN_W-1:0] gain_integ;
    logic [GAIN_W-1:0] gain_deriv;
    logic [SENS_W-1:0] steer_sens;
  } cfg_regs_t;

  function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [SPEED_W-1:0] r;
    if (v > S16_MAX) begin
      r = SPEED_W'(S16_MAX);
    end else if (v < S16_MIN) begin
      r = SPEED_W'(S16_MIN);
    end else begin
      r = SPEED_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hpw_ifs.sv =====
// ----------------------------------------------------------------------------
// hpw channel interfaces
// Command, result and configuration write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpw_cmd_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic        [hpw_pkg::HEAD_W-1:0] target_heading;
  logic        [hpw_pkg::HEAD_W-1:0] measured_heading;
  logic signed [hpw_pkg::SPEED_W-1:0] cruise_speed;

  modport source (output valid, kind, target_heading, measured_heading, cruise_speed,
                  input ready);
  modport sink   (input valid, kind, target_heading, measured_heading, cruise_speed,
                  output ready);
endinterface

interface hpw_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [hpw_pkg::SPEED_W-1:0] left_speed;
  logic signed [hpw_pkg::SPEED_W-1:0] right_speed;
  logic signed [hpw_pkg::SPEED_W-1:0] correction;
  logic signed [hpw_pkg::HEAD_W-1:0]  heading_error;

  modport source (output valid, left_speed, right_speed, correction, heading_error,
                  input ready);
  modport sink   (input valid, left_speed, right_speed, correction, heading_error,
                  output ready);
endinterface

interface hpw_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hpw_pkg::CFG_IDX_W-1:0]     index;
  logic [hpw_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/hpw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hpw_cfg_regs
// Gain and steering sensitivity registers behind the configuration channel.
// ----------------------------------------------------------------------------
module hpw_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  hpw_cfg_if.sink            cfg,
  output hpw_pkg::cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_prop  <= hpw_pkg::GAIN_PROP_RST;
      regs.gain_integ <= hpw_pkg::GAIN_INTEG_RST;
      regs.gain_deriv <= hpw_pkg::GAIN_DERIV_RST;
      regs.steer_sens <= hpw_pkg::STEER_SENS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        hpw_pkg::REG_GAIN_PROP:  regs.gain_prop  <= cfg.data;
        hpw_pkg::REG_GAIN_INTEG: regs.gain_integ <= cfg.data;
        hpw_pkg::REG_GAIN_DERIV: regs.gain_deriv <= cfg.data;
        hpw_pkg::REG_STEER_SENS: regs.steer_sens <= cfg.data[hpw_pkg::SENS_W-1:0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

endmodule

// ===== rtl/core/hpw_mul.sv =====
// ----------------------------------------------------------------------------
// hpw_mul
// Shared signed multiplier with registered product; holds when not enabled.
// ----------------------------------------------------------------------------
module hpw_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [hpw_pkg::MUL_A_W-1:0]  a,
  input  logic signed [hpw_pkg::MUL_B_W-1:0]  b,
  output logic signed [hpw_pkg::PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= hpw_pkg::PROD_W'(a) * hpw_pkg::PROD_W'(b);
    end
  end

endmodule

// ===== rtl/core/hpw_seq.sv =====
// ----------------------------------------------------------------------------
// hpw_seq
// Step sequencer: walks one update through error, products, clamp and output.
// ----------------------------------------------------------------------------
module hpw_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_kind,
  input  logic               out_busy,
  output hpw_pkg::seq_ctrl_t ctrl
);

  hpw_pkg::state_t state;
  hpw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctrl.cmd_ready = 1'b0;
    ctrl.out_load  = 1'b0;
    ctrl.mul_en    = 1'b0;
    ctrl.step      = state;
    case (state)
      hpw_pkg::ST_IDLE: begin
        ctrl.cmd_ready = 1'b1;
        // a clear transaction finishes here
        if (cmd_valid && !cmd_kind) state_next = hpw_pkg::ST_ERR;
      end
      hpw_pkg::ST_ERR:     state_next = hpw_pkg::ST_MUL_P;
      hpw_pkg::ST_MUL_P: begin
        ctrl.mul_en = 1'b1;
        state_next  = hpw_pkg::ST_MUL_D;
      end
      hpw_pkg::ST_MUL_D: begin
        ctrl.mul_en = 1'b1;
        state_next  = hpw_pkg::ST_MUL_ILO;
      end
      hpw_pkg::ST_MUL_ILO: begin
        ctrl.mul_en = 1'b1;
        state_next  = hpw_pkg::ST_MUL_IHI;
      end
      hpw_pkg::ST_MUL_IHI: begin
        ctrl.mul_en = 1'b1;
        state_next  = hpw_pkg::ST_CLAMP;
      end
      hpw_pkg::ST_CLAMP:   state_next = hpw_pkg::ST_ADD_I;
      hpw_pkg::ST_ADD_I:   state_next = hpw_pkg::ST_CORR;
      hpw_pkg::ST_CORR:    state_next = hpw_pkg::ST_MUL_S;
      hpw_pkg::ST_MUL_S: begin
        ctrl.mul_en = 1'b1;
        state_next  = hpw_pkg::ST_OUT;
      end
      hpw_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_busy) begin
          ctrl.out_load = 1'b1;
          state_next    = hpw_pkg::ST_IDLE;
        end
      end
      default: state_next = hpw_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/heading_pid_wheel_speeds.sv =====
// ----------------------------------------------------------------------------
// heading_pid_wheel_speeds
// Heading PID for a differential drive: wrapped heading error, saturating
// error sum, PID correction and left/right wheel speeds.
//
//   channel  dir  handshake     payload
//   cmd      in   valid/ready   kind, target_heading, measured_heading, cruise_speed
//   res      out  valid/ready   left_speed, right_speed, correction, heading_error
//   cfg      in   valid/ready   index, data (ready always high)
//
// An update runs from acceptance to the result register through the error
// step, five products issued in turn through one 25x26 multiplier and the
// clamp, sum and saturation steps; the next command is taken once the
// result is loaded. A clear transaction is taken in idle, gives no result.
// Synchronous reset zeroes the error sum and last error and reloads the gains.
// A waiting result sits in the output register; a new command is accepted
// meanwhile, and the final step holds while that register is still full.
// ----------------------------------------------------------------------------
module heading_pid_wheel_speeds #(
  parameter int ANGLE_BITS = hpw_pkg::ANGLE_BITS_DEF,
  parameter int SUM_BITS   = hpw_pkg::SUM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hpw_cmd_if.sink    cmd,
  hpw_res_if.source  res,
  hpw_cfg_if.sink    cfg
);

  localparam int SW = ((SUM_BITS > ANGLE_BITS) ? SUM_BITS : ANGLE_BITS) + 1;
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic [hpw_pkg::IP_W-1:0] CLAMP_LIM =
    {{(hpw_pkg::IP_W-hpw_pkg::ICL_W){1'b0}}, 1'b1, {hpw_pkg::CLAMP_EXP{1'b0}}};

  hpw_pkg::cfg_regs_t regs;
  hpw_pkg::seq_ctrl_t ctrl;

  logic        [ANGLE_BITS-1:0]           tgt_r;
  logic        [ANGLE_BITS-1:0]           meas_r;
  logic signed [hpw_pkg::SPEED_W-1:0]     base_r;
  logic signed [ANGLE_BITS-1:0]           err_r;
  logic signed [ANGLE_BITS:0]             deriv_r;
  logic signed [ANGLE_BITS-1:0]           last_error;
  logic signed [SUM_BITS-1:0]             error_sum;
  logic                                   sum_neg;
  logic        [hpw_pkg::MAG_W-1:0]       mag_r;
  logic signed [hpw_pkg::ACC_W-1:0]       acc;
  logic        [hpw_pkg::MAG_W-1:0]       ip_lo;
  logic        [hpw_pkg::ICL_W-1:0]       icl;
  logic signed [hpw_pkg::SPEED_W-1:0]     corr_r;
  logic                                   res_valid;
  logic signed [hpw_pkg::SPEED_W-1:0]     left_r;
  logic signed [hpw_pkg::SPEED_W-1:0]     right_r;
  logic signed [hpw_pkg::SPEED_W-1:0]     corr_out;
  logic signed [hpw_pkg::HEAD_W-1:0]      herr_out;

  logic signed [hpw_pkg::MUL_A_W-1:0]     mul_a;
  logic signed [hpw_pkg::MUL_B_W-1:0]     mul_b;
  logic signed [hpw_pkg::PROD_W-1:0]      prod;

  logic        [ANGLE_BITS-1:0]           diff;
  logic signed [ANGLE_BITS-1:0]           err_c;
  logic signed [SW-1:0]                   sum_wide;
  logic signed [SUM_BITS-1:0]             sum_next;
  logic signed [hpw_pkg::MAG_W:0]         sum_x;
  logic signed [hpw_pkg::MAG_W:0]         mag_c;
  logic        [hpw_pkg::IP_W-1:0]        ip_full;
  logic signed [hpw_pkg::PROD_W-1:0]      scaled;
  logic                                   cmd_fire;
  logic                                   out_busy;

  hpw_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  hpw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_kind  (cmd.kind),
    .out_busy  (out_busy),
    .ctrl      (ctrl)
  );

  hpw_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign cmd.ready = ctrl.cmd_ready;
  assign cmd_fire  = cmd.valid && ctrl.cmd_ready;
  assign out_busy  = res_valid && !res.ready;

  // wrapped error: two's complement view of the modular difference
  assign diff     = meas_r - tgt_r;
  assign err_c    = $signed(diff);
  assign sum_wide = SW'(error_sum) + SW'(err_c);
  assign sum_x    = (hpw_pkg::MAG_W+1)'(error_sum);
  assign mag_c    = error_sum[SUM_BITS-1] ? -sum_x : sum_x;
  assign ip_full  = {prod[hpw_pkg::MAG_W-1:0], {hpw_pkg::SLICE_W{1'b0}}}
                  + hpw_pkg::IP_W'(ip_lo);
  assign scaled   = prod >>> hpw_pkg::SENS_SHIFT;

  always_comb begin
    if (sum_wide > SW'(SUM_MAX)) begin
      sum_next = SUM_MAX;
    end else if (sum_wide < SW'(SUM_MIN)) begin
      sum_next = SUM_MIN;
    end else begin
      sum_next = SUM_BITS'(sum_wide);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.step)
      hpw_pkg::ST_MUL_P: begin
        mul_a = $signed(hpw_pkg::MUL_A_W'(regs.gain_prop));
        mul_b = hpw_pkg::MUL_B_W'(err_r);
      end
      hpw_pkg::ST_MUL_D: begin
        mul_a = $signed(hpw_pkg::MUL_A_W'(regs.gain_deriv));
        mul_b = hpw_pkg::MUL_B_W'(deriv_r);
      end
      hpw_pkg::ST_MUL_ILO: begin
        mul_a = $signed(hpw_pkg::MUL_A_W'(regs.gain_integ));
        mul_b = $signed(hpw_pkg::MUL_B_W'(mag_r[hpw_pkg::SLICE_W-1:0]));
      end
      hpw_pkg::ST_MUL_IHI: begin
        mul_a = $signed(hpw_pkg::MUL_A_W'(regs.gain_integ));
        mul_b = $signed(hpw_pkg::MUL_B_W'(mag_r[hpw_pkg::MAG_W-1:hpw_pkg::SLICE_W]));
      end
      hpw_pkg::ST_MUL_S: begin
        mul_a = $signed(hpw_pkg::MUL_A_W'(regs.steer_sens));
        mul_b = hpw_pkg::MUL_B_W'(corr_r);
      end
      default: ;
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
    end else if (cmd_fire && cmd.kind) begin
      last_error <= '0;
      error_sum  <= '0;
    end else if (ctrl.step == hpw_pkg::ST_ERR) begin
      last_error <= err_c;
      error_sum  <= sum_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      tgt_r  <= ANGLE_BITS'(cmd.target_heading);
      meas_r <= ANGLE_BITS'(cmd.measured_heading);
      base_r <= cmd.cruise_speed;
    end
    case (ctrl.step)
      hpw_pkg::ST_ERR: begin
        err_r   <= err_c;
        deriv_r <= (ANGLE_BITS+1)'(err_c) - (ANGLE_BITS+1)'(last_error);
      end
      hpw_pkg::ST_MUL_P: begin
        sum_neg <= error_sum[SUM_BITS-1];
        mag_r   <= hpw_pkg::MAG_W'(mag_c);
      end
      hpw_pkg::ST_MUL_D:   acc   <= hpw_pkg::ACC_W'(prod);
      hpw_pkg::ST_MUL_ILO: acc   <= acc + hpw_pkg::ACC_W'(prod);
      hpw_pkg::ST_MUL_IHI: ip_lo <= prod[hpw_pkg::MAG_W-1:0];
      hpw_pkg::ST_CLAMP: begin
        icl <= (ip_full > CLAMP_LIM) ? CLAMP_LIM[hpw_pkg::ICL_W-1:0]
                                     : ip_full[hpw_pkg::ICL_W-1:0];
      end
      hpw_pkg::ST_ADD_I: begin
        if (sum_neg) begin
          acc <= acc - $signed(hpw_pkg::ACC_W'(icl));
        end else begin
          acc <= acc + $signed(hpw_pkg::ACC_W'(icl));
        end
      end
      hpw_pkg::ST_CORR: corr_r <= hpw_pkg::sat16(acc >>> hpw_pkg::CORR_SHIFT);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      left_r   <= hpw_pkg::sat16(hpw_pkg::ACC_W'(base_r) + hpw_pkg::ACC_W'(scaled));
      right_r  <= hpw_pkg::sat16(hpw_pkg::ACC_W'(base_r) - hpw_pkg::ACC_W'(scaled));
      corr_out <= corr_r;
      herr_out <= hpw_pkg::sat16(hpw_pkg::ACC_W'(err_r));
    end
  end

  assign res.valid         = res_valid;
  assign res.left_speed    = left_r;
  assign res.right_speed   = right_r;
  assign res.correction    = corr_out;
  assign res.heading_error = herr_out;

endmodule

// ===== rtl/core/hpw_checker.sv =====
// ----------------------------------------------------------------------------
// hpw_checker
// Port-level checks on the heading PID block, bound to the top level.
// ----------------------------------------------------------------------------
module hpw_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_ready,
  input logic                               cmd_kind,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic signed [hpw_pkg::SPEED_W-1:0] res_left_speed
);

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // an update keeps the block busy
  a_upd_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && !cmd_kind) |=> !cmd_ready)
    else $error("command taken during an update");

  // a clear finishes in its own cycle
  a_clr_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd_kind) |=> cmd_ready)
    else $error("clear transaction stalled the block");

  // no result can follow a command in the next cycle
  a_no_fast_res: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !$rose(res_valid))
    else $error("result appeared right after a command");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_left_speed)))
    else $error("stalled result changed");

endmodule

bind heading_pid_wheel_speeds hpw_checker u_hpw_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .cmd_kind       (cmd.kind),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_left_speed (res.left_speed)
);
